// File: hw/rtl/spl_pkg.sv
// Package for the shared-pool linked stacks: sizes, operation codes,
// stream word layouts and the controller state type.
// No dependencies; the top level and the testbench refer to it by scoped names.
package spl_pkg;

  localparam int POOL_DEPTH  = 1024;
  localparam int STACK_COUNT = 4;
  localparam int DATA_WIDTH  = 32;

  // Node index width, and pointer width with room for the null value.
  localparam int ADDR_W = $clog2(POOL_DEPTH);
  localparam int PTR_W  = ADDR_W + 1;

  localparam int FUNC_W = 2;
  localparam int SID_W  = 2;

  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_DEPTH);

  // Input word: func, stack_id, push_value from the lowest bit up.
  localparam int IN_W        = FUNC_W + SID_W + DATA_WIDTH;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int IN_FUNC_LO  = 0;
  localparam int IN_SID_LO   = FUNC_W;
  localparam int IN_VAL_LO   = FUNC_W + SID_W;

  // Output word: ok, top_value, stack_empty from the lowest bit up.
  localparam int OUT_W       = 1 + DATA_WIDTH + 1;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PEEK = 2'd2;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic                  ok;
    logic [DATA_WIDTH-1:0] top_value;
    logic                  stack_empty;
  } result_t;

endpackage

// File: hw/rtl/spl_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing; used for the link and data stores of the node pool.
module spl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: hw/rtl/shared_pool_linked_stacks.sv
// Top level of the shared-pool linked stacks; uses spl_pkg and spl_ram.
// Holds the controller, the stack top registers and the free list head.

// Four LIFO stacks share a pool of 1024 nodes held in two RAMs (link and
// data). For each word, in the accept cycle the link and data RAMs are
// read, in the next cycle the result is formed, the RAMs are written back
// and the result word is loaded into the output register. No new word is
// accepted in the execute cycle, only once the block is idle; a waiting
// result holds off the next word only if it is still untaken when that word
// arrives. No clearing pass is needed after reset: a fill count marks the
// nodes never handed out, whose free list link is simply the next index.
module shared_pool_linked_stacks (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // func [1:0], stack_id [3:2], push_value [35:4], zero fill above
  input  logic [spl_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // ok [0], top_value [32:1], stack_empty [33], zero fill above
  output logic [spl_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int PW = spl_pkg::PTR_W;
  localparam int AW = spl_pkg::ADDR_W;
  localparam int DW = spl_pkg::DATA_WIDTH;

  spl_pkg::state_e state_q, state_d;

  logic [spl_pkg::FUNC_W-1:0] in_func;
  logic [spl_pkg::SID_W-1:0]  in_sid;
  logic [DW-1:0]              in_val;
  logic                       in_sid_ok;
  logic [PW-1:0]              in_top;
  logic                       accept;

  logic [spl_pkg::FUNC_W-1:0] func_q;
  logic [spl_pkg::SID_W-1:0]  sid_q;
  logic [DW-1:0]              val_q;
  logic [PW-1:0]              top_q;
  logic                       sid_ok_q;

  logic [PW-1:0] free_head_q, free_head_d;
  logic [PW-1:0] fill_q, fill_d;
  logic [PW-1:0] stack_top_q [spl_pkg::STACK_COUNT];
  logic [PW-1:0] stack_top_d;
  logic          top_we;

  logic          out_valid_q;
  spl_pkg::result_t out_q, out_d;

  logic          link_re;
  logic [AW-1:0] link_raddr;
  logic [PW-1:0] link_rdata;
  logic          link_we;
  logic [AW-1:0] link_waddr;
  logic [PW-1:0] link_wdata;

  logic          data_we;
  logic [DW-1:0] data_rdata;

  logic          head_is_node;
  logic          head_fresh;
  logic          top_is_node;
  logic          exec;

  assign in_func   = s_axis_tdata_i[spl_pkg::IN_FUNC_LO +: spl_pkg::FUNC_W];
  assign in_sid    = s_axis_tdata_i[spl_pkg::IN_SID_LO +: spl_pkg::SID_W];
  assign in_val    = s_axis_tdata_i[spl_pkg::IN_VAL_LO +: DW];
  assign in_sid_ok = (32'(in_sid) < 32'(spl_pkg::STACK_COUNT));
  assign in_top    = in_sid_ok ? stack_top_q[in_sid] : spl_pkg::NULL_PTR;
  assign accept    = s_axis_tvalid_i && s_axis_tready_o;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      spl_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = spl_pkg::ST_EXEC;
        end
      end
      spl_pkg::ST_EXEC: state_d = spl_pkg::ST_IDLE;
      default:          state_d = spl_pkg::ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    exec            = 1'b0;
    case (state_q)
      spl_pkg::ST_IDLE: s_axis_tready_o = !out_valid_q || m_axis_tready_i;
      spl_pkg::ST_EXEC: exec = 1'b1;
      default:          s_axis_tready_o = 1'b0;
    endcase
  end

  // A push reads the link of the free head, a pop the link of the stack top.
  assign link_re    = accept;
  assign link_raddr = (in_func == spl_pkg::FUNC_PUSH) ? free_head_q[AW-1:0]
                                                       : in_top[AW-1:0];

  assign head_is_node = free_head_q < spl_pkg::NULL_PTR;
  assign head_fresh   = free_head_q >= fill_q;
  assign top_is_node  = top_q < spl_pkg::NULL_PTR;

  // Execute cycle: read data is valid, work out the write-back and result.
  always_comb begin
    free_head_d = free_head_q;
    fill_d      = fill_q;
    stack_top_d = top_q;
    top_we      = 1'b0;
    link_we     = 1'b0;
    link_waddr  = top_q[AW-1:0];
    link_wdata  = free_head_q;
    data_we     = 1'b0;
    out_d.ok          = 1'b0;
    out_d.top_value   = '0;
    out_d.stack_empty = !top_is_node;
    if (!sid_ok_q) begin
      out_d.stack_empty = 1'b1;
    end else begin
      case (func_q)
        spl_pkg::FUNC_PUSH: begin
          if (head_is_node) begin
            // Nodes at or above the fill count were never handed out, so
            // their free list link is still the next index.
            if (head_fresh) begin
              free_head_d = free_head_q + PW'(1);
              fill_d      = fill_q + PW'(1);
            end else begin
              free_head_d = link_rdata;
            end
            link_we     = exec;
            link_waddr  = free_head_q[AW-1:0];
            link_wdata  = top_q;
            data_we     = exec;
            stack_top_d = free_head_q;
            top_we      = exec;
            out_d.ok          = 1'b1;
            out_d.stack_empty = 1'b0;
          end
        end
        spl_pkg::FUNC_POP: begin
          if (top_is_node) begin
            stack_top_d = link_rdata;
            top_we      = exec;
            link_we     = exec;
            free_head_d = top_q;
            out_d.ok          = 1'b1;
            out_d.stack_empty = !(link_rdata < spl_pkg::NULL_PTR);
          end
        end
        spl_pkg::FUNC_PEEK: begin
          if (top_is_node) begin
            out_d.ok        = 1'b1;
            out_d.top_value = data_rdata;
          end
        end
        default: out_d.ok = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spl_pkg::ST_IDLE;
      free_head_q <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < spl_pkg::STACK_COUNT; i++) begin
        stack_top_q[i] <= spl_pkg::NULL_PTR;
      end
    end else begin
      state_q <= state_d;
      if (exec) begin
        free_head_q <= free_head_d;
        fill_q      <= fill_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (top_we) begin
        stack_top_q[sid_q] <= stack_top_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q   <= in_func;
      sid_q    <= in_sid;
      val_q    <= in_val;
      top_q    <= in_top;
      sid_ok_q <= in_sid_ok;
    end
    if (exec) begin
      out_q <= out_d;
    end
  end

  spl_ram #(
    .WIDTH (PW),
    .DEPTH (spl_pkg::POOL_DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (link_re),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  spl_ram #(
    .WIDTH (DW),
    .DEPTH (spl_pkg::POOL_DEPTH)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (free_head_q[AW-1:0]),
    .wdata_i (val_q),
    .re_i    (accept),
    .raddr_i (in_top[AW-1:0]),
    .rdata_o (data_rdata)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = spl_pkg::OUT_TDATA_W'({out_q.stack_empty, out_q.top_value,
                                                  out_q.ok});

endmodule

// File: verif/tb_shared_pool_linked_stacks.sv
// Self-checking testbench for shared_pool_linked_stacks: a table of directed words, then
// weighted random push, pop and peek traffic that fills the pool and then leans towards pops.
// Depends on spl_pkg and the RTL of the block only.
module tb_shared_pool_linked_stacks;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [spl_pkg::FUNC_W-1:0] FUNC_NONE  = 2'd3;
  localparam int                         RAND_ITEMS = 1825;
  localparam int                         FULL_ITEMS = 40;
  localparam int                         IDLE_LIMIT = 4000;
  localparam int                         DIR_N      = 25;

  typedef struct packed {
    logic [spl_pkg::FUNC_W-1:0]     fn;
    logic [spl_pkg::SID_W-1:0]      sid;
    logic [spl_pkg::DATA_WIDTH-1:0] val;
    logic                           typed;
    spl_pkg::result_t               res;
  } dir_row_t;

  logic                            clk_i = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [spl_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [spl_pkg::OUT_TDATA_W-1:0] m_tdata;

  // Shadow copy of the node pool, the free list and the stack tops.
  logic [spl_pkg::PTR_W-1:0]      link_mem [spl_pkg::POOL_DEPTH];
  logic [spl_pkg::DATA_WIDTH-1:0] data_mem [spl_pkg::POOL_DEPTH];
  logic [spl_pkg::PTR_W-1:0]      free_ptr;
  logic [spl_pkg::PTR_W-1:0]      top_ptr [spl_pkg::STACK_COUNT];
  int                             nodes_in_use;

  spl_pkg::result_t expected_q [$];
  int      err_cnt    = 0;
  int      idle_cycles = 0;
  int      burst_left = 0;
  logic [15:0] ready_pat = '1;
  int      pat_age    = 0;

  // Where the result is obvious from the state it is written here; other rows use the shadow.
  dir_row_t dir_tab [DIR_N] = '{
    '{spl_pkg::FUNC_PEEK, 2'd0, 32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 1'b1}},
    '{spl_pkg::FUNC_POP,  2'd1, 32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 1'b1}},
    '{FUNC_NONE,          2'd2, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0000_0000, 1'b1}},
    '{spl_pkg::FUNC_PUSH, 2'd0, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0000_0000, 1'b0}},
    '{spl_pkg::FUNC_PEEK, 2'd0, 32'h0000_0000, 1'b1, '{1'b1, 32'hFFFF_FFFF, 1'b0}},
    '{spl_pkg::FUNC_PUSH, 2'd0, 32'h0000_0000, 1'b1, '{1'b1, 32'h0000_0000, 1'b0}},
    '{spl_pkg::FUNC_PEEK, 2'd0, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0000_0000, 1'b0}},
    '{FUNC_NONE,          2'd0, 32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 1'b0}},
    '{spl_pkg::FUNC_PUSH, 2'd3, 32'hA5A5_A5A5, 1'b0, '0},
    '{spl_pkg::FUNC_PUSH, 2'd1, 32'h5A5A_5A5A, 1'b0, '0},
    '{spl_pkg::FUNC_PEEK, 2'd3, 32'h0000_0000, 1'b0, '0},
    '{spl_pkg::FUNC_POP,  2'd0, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0000_0000, 1'b0}},
    '{spl_pkg::FUNC_PEEK, 2'd0, 32'h0000_0000, 1'b1, '{1'b1, 32'hFFFF_FFFF, 1'b0}},
    '{spl_pkg::FUNC_POP,  2'd0, 32'h0000_0000, 1'b1, '{1'b1, 32'h0000_0000, 1'b1}},
    '{spl_pkg::FUNC_POP,  2'd0, 32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 1'b1}},
    '{spl_pkg::FUNC_PUSH, 2'd2, 32'h8000_0001, 1'b0, '0},
    '{spl_pkg::FUNC_POP,  2'd3, 32'h0000_0000, 1'b0, '0},
    '{spl_pkg::FUNC_PUSH, 2'd3, 32'h0000_0001, 1'b0, '0},
    '{spl_pkg::FUNC_PEEK, 2'd3, 32'h0000_0000, 1'b0, '0},
    '{spl_pkg::FUNC_PEEK, 2'd1, 32'h0000_0000, 1'b0, '0},
    '{spl_pkg::FUNC_POP,  2'd1, 32'h0000_0000, 1'b0, '0},
    '{spl_pkg::FUNC_PEEK, 2'd2, 32'h0000_0000, 1'b0, '0},
    '{FUNC_NONE,          2'd3, 32'h0000_0000, 1'b0, '0},
    '{spl_pkg::FUNC_POP,  2'd2, 32'h0000_0000, 1'b0, '0},
    '{spl_pkg::FUNC_POP,  2'd3, 32'h0000_0000, 1'b0, '0}
  };

  shared_pool_linked_stacks DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic bit is_node(logic [spl_pkg::PTR_W-1:0] p);
    return int'(p) < spl_pkg::POOL_DEPTH;
  endfunction

  // Applies one operation to the shadow pool and returns the word the block should send.
  function automatic spl_pkg::result_t apply_stack_op(logic [spl_pkg::FUNC_W-1:0] fn,
                                                      logic [spl_pkg::SID_W-1:0] sid,
                                                      logic [spl_pkg::DATA_WIDTH-1:0] val);
    spl_pkg::result_t          r;
    logic [spl_pkg::PTR_W-1:0] n;
    r = '{1'b0, '0, 1'b1};
    if (int'(sid) < spl_pkg::STACK_COUNT) begin
      case (fn)
        spl_pkg::FUNC_PUSH: begin
          n = free_ptr;
          if (is_node(n)) begin
            free_ptr       = link_mem[n[spl_pkg::ADDR_W-1:0]];
            data_mem[n[spl_pkg::ADDR_W-1:0]] = val;
            link_mem[n[spl_pkg::ADDR_W-1:0]] = top_ptr[sid];
            top_ptr[sid]   = n;
            nodes_in_use++;
            r.ok = 1'b1;
          end
        end
        spl_pkg::FUNC_POP: begin
          n = top_ptr[sid];
          if (is_node(n)) begin
            top_ptr[sid]   = link_mem[n[spl_pkg::ADDR_W-1:0]];
            link_mem[n[spl_pkg::ADDR_W-1:0]] = free_ptr;
            free_ptr       = n;
            nodes_in_use--;
            r.ok = 1'b1;
          end
        end
        spl_pkg::FUNC_PEEK: begin
          n = top_ptr[sid];
          if (is_node(n)) begin
            r.ok        = 1'b1;
            r.top_value = data_mem[n[spl_pkg::ADDR_W-1:0]];
          end
        end
        default: ;
      endcase
      r.stack_empty = !is_node(top_ptr[sid]);
    end
    return r;
  endfunction

  // Holds the word on the bus until it is taken, then ends the burst or carries on.
  task automatic send_word(logic [spl_pkg::FUNC_W-1:0] fn, logic [spl_pkg::SID_W-1:0] sid,
                           logic [spl_pkg::DATA_WIDTH-1:0] val, logic typed,
                           spl_pkg::result_t typed_res);
    spl_pkg::result_t pred;
    s_tvalid <= 1'b1;
    s_tdata  <= spl_pkg::IN_TDATA_W'({val, sid, fn});
    do @(posedge clk_i); while (!s_tready);
    pred = apply_stack_op(fn, sid, val);
    expected_q.push_back(typed ? typed_res : pred);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 90) : $urandom_range(0, 15);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_random(int push_pct, int pop_pct, int peek_pct);
    int                             r;
    logic [spl_pkg::FUNC_W-1:0]     fn;
    logic [spl_pkg::DATA_WIDTH-1:0] val;
    r = $urandom_range(0, 99);
    if (r < push_pct)                           fn = spl_pkg::FUNC_PUSH;
    else if (r < push_pct + pop_pct)            fn = spl_pkg::FUNC_POP;
    else if (r < push_pct + pop_pct + peek_pct) fn = spl_pkg::FUNC_PEEK;
    else                                        fn = FUNC_NONE;
    case ($urandom_range(0, 7))
      0:       val = '0;
      1:       val = '1;
      2:       val = spl_pkg::DATA_WIDTH'(1) << $urandom_range(0, spl_pkg::DATA_WIDTH - 1);
      default: val = $urandom;
    endcase
    send_word(fn, spl_pkg::SID_W'($urandom_range(0, 3)), val, 1'b0, '0);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: a rotating ready pattern, reloaded now and then with a new density.
  always @(posedge clk_i) begin
    if (pat_age == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_pat <= '1;
        1:       ready_pat <= 16'($urandom);
        2:       ready_pat <= 16'($urandom | $urandom);
        default: ready_pat <= 16'($urandom & $urandom) | 16'h0001;
      endcase
      pat_age <= $urandom_range(32, 200);
    end else begin
      ready_pat <= {ready_pat[0], ready_pat[15:1]};
      pat_age   <= pat_age - 1;
    end
    m_tready <= ready_pat[0];
  end

  always @(posedge clk_i) begin
    spl_pkg::result_t exp_res;
    spl_pkg::result_t got;
    if (rst_n && m_tvalid && m_tready) begin
      got.ok          = m_tdata[0];
      got.top_value   = m_tdata[spl_pkg::DATA_WIDTH:1];
      got.stack_empty = m_tdata[spl_pkg::DATA_WIDTH+1];
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, m_tdata);
        err_cnt++;
      end else begin
        exp_res = expected_q.pop_front();
        if (got.ok !== exp_res.ok) begin
          $display("%0t: ok expected %0b got %0b", $time, exp_res.ok, got.ok);
          err_cnt++;
        end
        if (got.top_value !== exp_res.top_value) begin
          $display("%0t: top_value expected %h got %h", $time, exp_res.top_value,
                   got.top_value);
          err_cnt++;
        end
        if (got.stack_empty !== exp_res.stack_empty) begin
          $display("%0t: stack_empty expected %0b got %0b", $time, exp_res.stack_empty,
                   got.stack_empty);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int rand_cnt;
    int full_left;
    bit pool_filled;
    rand_cnt    = 0;
    full_left   = FULL_ITEMS;
    pool_filled = 1'b0;
    for (int i = 0; i < spl_pkg::POOL_DEPTH; i++) begin
      link_mem[i] = spl_pkg::PTR_W'(i + 1);
      data_mem[i] = '0;
    end
    for (int s = 0; s < spl_pkg::STACK_COUNT; s++) top_ptr[s] = spl_pkg::NULL_PTR;
    free_ptr     = '0;
    nodes_in_use = 0;

    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      send_word(dir_tab[i].fn, dir_tab[i].sid, dir_tab[i].val, dir_tab[i].typed,
                dir_tab[i].res);
    end
    drain_results();

    // Fill the pool until pushes fail, stay full for a while, then lean towards pops.
    while (!pool_filled || full_left > 0 || rand_cnt < RAND_ITEMS) begin
      if (!pool_filled) begin
        send_random(88, 6, 4);
        pool_filled = (nodes_in_use == spl_pkg::POOL_DEPTH);
      end else if (full_left > 0) begin
        send_random(70, 10, 15);
        full_left--;
        if (full_left == 0) drain_results();
      end else begin
        send_random(25, 55, 15);
      end
      rand_cnt++;
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/spl_pkg.sv
hw/rtl/spl_ram.sv
hw/rtl/shared_pool_linked_stacks.sv
verif/tb_shared_pool_linked_stacks.sv
